[design/kmdb_pkg.sv]
package kmdb_pkg;

	localparam int MODE_W  = 2;
	localparam int PRESS_W = 42;
	localparam int TIDX_W  = 6;
	localparam int CODE_W  = 8;
	localparam int KIND_W  = 2;
	localparam int POS_W   = 3;
	localparam int OUTC_W  = 3;
	localparam int REP_W   = 6;
	localparam int FILLO_W = 3;
	localparam int KEYS_W  = 48;
	localparam int THR_W   = 8;
	localparam int CNT_BITS = 8;

	localparam logic [THR_W-1:0] THRESH_RESET = 8'd50;

	localparam logic [MODE_W-1:0] MODE_SCAN   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TABLE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic [KIND_W-1:0] KIND_CROSS   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TABLE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd3;

	localparam logic [OUTC_W-1:0] OUTC_ADDED   = 3'd0;
	localparam logic [OUTC_W-1:0] OUTC_PRESENT = 3'd1;
	localparam logic [OUTC_W-1:0] OUTC_FULL    = 3'd2;
	localparam logic [OUTC_W-1:0] OUTC_REMOVED = 3'd3;
	localparam logic [OUTC_W-1:0] OUTC_MISSING = 3'd4;

endpackage

[design/kmdb_if.sv]
interface kmdb_in_if;
	import kmdb_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [PRESS_W-1:0] rows_pressed;
	logic [TIDX_W-1:0]  table_index;
	logic [CODE_W-1:0]  key_code;

	modport source (output valid, mode, rows_pressed, table_index, key_code, input ready);
	modport sink   (input valid, mode, rows_pressed, table_index, key_code, output ready);
endinterface

interface kmdb_out_if;
	import kmdb_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [CODE_W-1:0]  event_code;
	logic [POS_W-1:0]   key_row;
	logic [POS_W-1:0]   key_col;
	logic [OUTC_W-1:0]  outcome;
	logic [REP_W-1:0]   keys_reported;
	logic [FILLO_W-1:0] buffer_fill;
	logic [KEYS_W-1:0]  buffer_keys;
	logic               last;

	modport source (output valid, kind, event_code, key_row, key_col, outcome, keys_reported,
		buffer_fill, buffer_keys, last, input ready);
	modport sink   (input valid, kind, event_code, key_row, key_col, outcome, keys_reported,
		buffer_fill, buffer_keys, last, output ready);
endinterface

[design/kmdb_lane.sv]
module kmdb_lane #(
	parameter int ROWS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  logic [ROWS-1:0]            pressed,
	input  logic [kmdb_pkg::THR_W-1:0] threshold,
	output logic [ROWS-1:0]            over_q
);
	import kmdb_pkg::*;

	logic [CNT_BITS-1:0] cnt_q [ROWS];
	logic [CNT_BITS-1:0] cnt_nxt [ROWS];
	logic [ROWS-1:0]     hit;

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			if (!pressed[r]) begin
				cnt_nxt[r] = '0;
			end else if (cnt_q[r] == {CNT_BITS{1'b1}}) begin
				cnt_nxt[r] = cnt_q[r];
			end else begin
				cnt_nxt[r] = cnt_q[r] + 1'b1;
			end
			hit[r] = cnt_nxt[r] > threshold;
		end
	end

	// a crossing counter is cleared at once; the walk only needs the flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				cnt_q[r] <= '0;
			end
			over_q <= '0;
		end else if (upd) begin
			for (int r = 0; r < ROWS; r++) begin
				cnt_q[r] <= hit[r] ? '0 : cnt_nxt[r];
			end
			over_q <= hit;
		end
	end

endmodule

[design/kmdb_merge.sv]
module kmdb_merge #(
	parameter int ROWS         = 6,
	parameter int COLS         = 7,
	parameter int BUFFER_SLOTS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	kmdb_in_if.sink              item,
	kmdb_out_if.source           result,
	input  logic [ROWS*COLS-1:0] over_flags
);
	import kmdb_pkg::*;

	localparam int NKEYS  = ROWS * COLS;
	localparam int KEY_W  = (NKEYS > 1) ? $clog2(NKEYS) : 1;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int CNT_W  = $clog2(NKEYS + 1);
	localparam int FILL_W = $clog2(BUFFER_SLOTS + 1);

	typedef logic [BUFFER_SLOTS-1:0][CODE_W-1:0] slots_t;
	typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_ADD, ST_SUM, ST_OP} state_t;

	state_t              state_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                op_rm_q;
	logic [CODE_W-1:0]   op_code_q;
	slots_t              slots_q;
	logic [FILL_W-1:0]   fill_q;
	logic [NKEYS-1:0]    tbl_vld_q;
	logic [CODE_W-1:0]   tbl_mem [NKEYS];
	logic [CODE_W-1:0]   rd_code_q;
	logic                rd_hit_q;

	logic                out_valid_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [CODE_W-1:0]   out_code_q;
	logic [POS_W-1:0]    out_row_q;
	logic [POS_W-1:0]    out_col_q;
	logic [OUTC_W-1:0]   out_outc_q;
	logic [REP_W-1:0]    out_rep_q;
	logic [FILLO_W-1:0]  out_fill_q;
	logic [KEYS_W-1:0]   out_keys_q;
	logic                out_last_q;

	logic                accept;
	logic                out_free;
	logic                out_load;
	logic                walk_last;
	logic [KEY_W-1:0]    rd_addr;
	logic [KEY_W-1:0]    flag_idx;
	logic [KEY_W-1:0]    wr_addr;
	logic                idx_ok;
	logic                tbl_we;
	logic [CODE_W-1:0]   cross_code;

	logic [OUTC_W-1:0]   add_outc;
	slots_t              add_slots;
	logic [FILL_W-1:0]   add_fill;
	logic [OUTC_W-1:0]   rm_outc;
	slots_t              rm_slots;
	slots_t              rm_shift;
	logic [FILL_W-1:0]   rm_fill;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;
	assign out_load   = out_free && ((state_q == ST_ADD) || (state_q == ST_SUM)
		|| (state_q == ST_OP));
	assign walk_last  = (row_q == ROW_W'(ROWS - 1)) && (col_q == COL_W'(COLS - 1));
	assign rd_addr    = KEY_W'(row_q * COLS + col_q);
	assign flag_idx   = KEY_W'(col_q * ROWS + row_q);
	assign wr_addr    = item.table_index[KEY_W-1:0];
	assign idx_ok     = {1'b0, item.table_index} < (TIDX_W + 1)'(NKEYS);
	assign tbl_we     = accept && (item.mode == MODE_TABLE) && idx_ok;
	assign cross_code = rd_hit_q ? rd_code_q : '0;

	// code table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[wr_addr] <= item.key_code;
		end
		rd_code_q <= tbl_mem[rd_addr];
		rd_hit_q  <= tbl_vld_q[rd_addr];
	end

	// add: zero or present first, then full
	always_comb begin
		logic present;
		present   = 1'b0;
		add_slots = slots_q;
		add_fill  = fill_q;
		for (int i = 0; i < BUFFER_SLOTS; i++) begin
			if ((FILL_W'(i) < fill_q) && (slots_q[i] == cross_code)) begin
				present = 1'b1;
			end
		end
		if ((cross_code == '0) || present) begin
			add_outc = OUTC_PRESENT;
		end else if (fill_q == FILL_W'(BUFFER_SLOTS)) begin
			add_outc = OUTC_FULL;
		end else begin
			add_outc = OUTC_ADDED;
			add_fill = fill_q + 1'b1;
			for (int i = 0; i < BUFFER_SLOTS; i++) begin
				if (FILL_W'(i) == fill_q) begin
					add_slots[i] = cross_code;
				end
			end
		end
	end

	// remove: first held match, later slots move down one
	always_comb begin
		logic seen;
		seen     = 1'b0;
		rm_shift = slots_q >> CODE_W;
		rm_slots = slots_q;
		for (int j = 0; j < BUFFER_SLOTS; j++) begin
			seen = seen | ((FILL_W'(j) < fill_q) && (slots_q[j] == op_code_q));
			if (seen) begin
				rm_slots[j] = rm_shift[j];
			end
		end
		rm_outc = seen ? OUTC_REMOVED : OUTC_MISSING;
		rm_fill = seen ? fill_q - 1'b1 : fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			op_rm_q     <= 1'b0;
			op_code_q   <= '0;
			slots_q     <= '0;
			fill_q      <= '0;
			tbl_vld_q   <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_CROSS;
			out_code_q  <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_outc_q  <= OUTC_ADDED;
			out_rep_q   <= '0;
			out_fill_q  <= '0;
			out_keys_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.mode)
							MODE_SCAN: begin
								row_q   <= '0;
								col_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_WALK;
							end
							MODE_TABLE: begin
								if (idx_ok) begin
									tbl_vld_q[wr_addr] <= 1'b1;
								end
								op_rm_q <= 1'b0;
								state_q <= ST_OP;
							end
							MODE_REMOVE: begin
								op_rm_q   <= 1'b1;
								op_code_q <= item.key_code;
								state_q   <= ST_OP;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (over_flags[flag_idx]) begin
						state_q <= ST_ADD;
					end else if (walk_last) begin
						state_q <= ST_SUM;
					end else if (row_q == ROW_W'(ROWS - 1)) begin
						row_q <= '0;
						col_q <= col_q + 1'b1;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				ST_ADD: begin
					if (out_free) begin
						out_kind_q  <= KIND_CROSS;
						out_code_q  <= cross_code;
						out_row_q   <= POS_W'(row_q);
						out_col_q   <= POS_W'(col_q);
						out_outc_q  <= add_outc;
						out_rep_q   <= '0;
						out_fill_q  <= FILLO_W'(add_fill);
						out_keys_q  <= KEYS_W'(add_slots);
						out_last_q  <= 1'b0;
						slots_q     <= add_slots;
						fill_q      <= add_fill;
						cnt_q       <= cnt_q + 1'b1;
						if (walk_last) begin
							state_q <= ST_SUM;
						end else begin
							state_q <= ST_WALK;
							if (row_q == ROW_W'(ROWS - 1)) begin
								row_q <= '0;
								col_q <= col_q + 1'b1;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end
					end
				end
				ST_SUM: begin
					if (out_free) begin
						out_kind_q  <= KIND_SUMMARY;
						out_code_q  <= '0;
						out_row_q   <= '0;
						out_col_q   <= '0;
						out_outc_q  <= OUTC_ADDED;
						out_rep_q   <= REP_W'(cnt_q);
						out_fill_q  <= FILLO_W'(fill_q);
						out_keys_q  <= KEYS_W'(slots_q);
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_OP: begin
					if (out_free) begin
						out_row_q   <= '0;
						out_col_q   <= '0;
						out_rep_q   <= '0;
						out_last_q  <= 1'b1;
						if (op_rm_q) begin
							out_kind_q <= KIND_REMOVE;
							out_code_q <= op_code_q;
							out_outc_q <= rm_outc;
							out_fill_q <= FILLO_W'(rm_fill);
							out_keys_q <= KEYS_W'(rm_slots);
							slots_q    <= rm_slots;
							fill_q     <= rm_fill;
						end else begin
							out_kind_q <= KIND_TABLE;
							out_code_q <= '0;
							out_outc_q <= OUTC_ADDED;
							out_fill_q <= FILLO_W'(fill_q);
							out_keys_q <= KEYS_W'(slots_q);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.kind          = out_kind_q;
	assign result.event_code    = out_code_q;
	assign result.key_row       = out_row_q;
	assign result.key_col       = out_col_q;
	assign result.outcome       = out_outc_q;
	assign result.keys_reported = out_rep_q;
	assign result.buffer_fill   = out_fill_q;
	assign result.buffer_keys   = out_keys_q;
	assign result.last          = out_last_q;

endmodule

[design/key_matrix_debounce_buffer.sv]
// channel   dir  handshake      payload
// item      in   valid/ready    mode, rows_pressed, table_index, key_code
// result    out  valid/ready    kind, event_code, key_row, key_col, outcome,
//                               keys_reported, buffer_fill, buffer_keys, last
// config    in   cfg_wr_en      cfg_wr_data (debounce_threshold)
//
// A scan request: the column lanes update all counters in the accept cycle, then the
// merge unit walks the keys one per cycle, with an extra ST_ADD step per crossing
// for the registered code table read; ST_ADD waits while the output is stalled.
// Table write and remove each pass through ST_OP to their result.
// Reset clears counters, buffer and table valid bits at once; no clearing pass.
// A stalled result holds the walk; the next request is taken while the final
// result still waits in the output register.
module key_matrix_debounce_buffer #(
	parameter int ROWS         = 6,
	parameter int COLS         = 7,
	parameter int BUFFER_SLOTS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [kmdb_pkg::THR_W-1:0] cfg_wr_data,
	kmdb_in_if.sink                    item,
	kmdb_out_if.source                 result
);
	import kmdb_pkg::*;

	localparam int NKEYS = ROWS * COLS;

	logic [THR_W-1:0] thr_q;
	logic [NKEYS-1:0] pressed_ext;
	logic [NKEYS-1:0] over_flags;
	logic             scan_upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	assign scan_upd = item.valid && item.ready && (item.mode == MODE_SCAN);

	for (genvar b = 0; b < NKEYS; b++) begin : g_bit
		if (b < PRESS_W) begin : g_in
			assign pressed_ext[b] = item.rows_pressed[b];
		end else begin : g_pad
			assign pressed_ext[b] = 1'b0;
		end
	end

	for (genvar c = 0; c < COLS; c++) begin : g_lane
		kmdb_lane #(
			.ROWS(ROWS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (scan_upd),
			.pressed  (pressed_ext[c*ROWS +: ROWS]),
			.threshold(thr_q),
			.over_q   (over_flags[c*ROWS +: ROWS])
		);
	end

	kmdb_merge #(
		.ROWS        (ROWS),
		.COLS        (COLS),
		.BUFFER_SLOTS(BUFFER_SLOTS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.over_flags(over_flags)
	);

endmodule

[design/kmdb_checker.sv]
module kmdb_checker #(
	parameter int BUFFER_SLOTS = 6
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic [kmdb_pkg::MODE_W-1:0]  item_mode,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [kmdb_pkg::KIND_W-1:0]  res_kind,
	input logic [kmdb_pkg::REP_W-1:0]   res_reported,
	input logic [kmdb_pkg::FILLO_W-1:0] res_fill,
	input logic [kmdb_pkg::KEYS_W-1:0]  res_keys,
	input logic                         res_last
);
	import kmdb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind)
			&& $stable(res_keys) && $stable(res_last))
		else $error("result dropped or changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_last == (res_kind != KIND_CROSS)))
		else $error("last flag does not match result kind");

	a_rep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != KIND_SUMMARY |-> res_reported == '0)
		else $error("keys_reported set outside a summary");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_mode == MODE_SCAN || item_mode == MODE_TABLE
			|| item_mode == MODE_REMOVE) |=> !item_ready)
		else $error("request taken while previous one still in work");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> int'(res_fill) <= BUFFER_SLOTS)
		else $error("buffer fill beyond slot count");

endmodule

bind key_matrix_debounce_buffer kmdb_checker #(
	.BUFFER_SLOTS(BUFFER_SLOTS)
) u_kmdb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_mode   (item.mode),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_kind    (result.kind),
	.res_reported(result.keys_reported),
	.res_fill    (result.buffer_fill),
	.res_keys    (result.buffer_keys),
	.res_last    (result.last)
);

[bench/tb.sv]
module tb;
	import kmdb_pkg::*;

	localparam int ROWS         = 6;
	localparam int COLS         = 7;
	localparam int BUFFER_SLOTS = 6;
	localparam int NKEYS        = ROWS * COLS;

	localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

	localparam int SINK_OPEN    = 0;
	localparam int SINK_RANDOM  = 1;
	localparam int SINK_PATTERN = 2;

	localparam int SETTLE_CYCLES    = 100;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int STALL_LIMIT      = 4000;

	localparam logic [PRESS_W-1:0] ALL_KEYS = '1;

	typedef struct {
		logic [MODE_W-1:0]  mode;
		logic [PRESS_W-1:0] rows_pressed;
		logic [TIDX_W-1:0]  table_index;
		logic [CODE_W-1:0]  key_code;
		bit                 drain_first;
	} key_req_t;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [CODE_W-1:0]  event_code;
		logic [POS_W-1:0]   key_row;
		logic [POS_W-1:0]   key_col;
		logic [OUTC_W-1:0]  outcome;
		logic [REP_W-1:0]   keys_reported;
		logic [FILLO_W-1:0] buffer_fill;
		logic [KEYS_W-1:0]  buffer_keys;
		logic               last;
	} key_event_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [THR_W-1:0]   cfg_wr_data;

	kmdb_in_if  item_ch();
	kmdb_out_if result_ch();

	key_matrix_debounce_buffer #(
		.ROWS(ROWS),
		.COLS(COLS),
		.BUFFER_SLOTS(BUFFER_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item(item_ch),
		.result(result_ch)
	);

	// debounce state as the block should hold it
	logic [7:0]          press_cnt [NKEYS];
	logic [CODE_W-1:0]   code_map [NKEYS];
	logic [CODE_W-1:0]   key_slots [BUFFER_SLOTS];
	logic [FILLO_W-1:0]  slot_count;
	logic [THR_W-1:0]    threshold_model;

	key_req_t            queued_requests [$];
	key_event_t          expected_events [$];
	key_req_t            shown_req;

	// generation-side state
	logic [PRESS_W-1:0]  held_mask;
	logic [CODE_W-1:0]   loaded_codes [$];

	bit                  run_failed = 1'b0;
	bit                  sender_bursty;
	int                  burst_left;
	int                  gap_left;
	int                  sink_style;
	logic [15:0]         stall_pattern;
	int                  pat_pos;
	bit                  long_hold_pending = 1'b0;
	int                  hold_left;
	int                  quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic key_event_t make_event(input logic [KIND_W-1:0] kind,
			input logic [CODE_W-1:0] code, input int row, input int col,
			input logic [OUTC_W-1:0] oc, input int reported, input bit is_last);
		key_event_t ev;
		ev.kind          = kind;
		ev.event_code    = code;
		ev.key_row       = POS_W'(row);
		ev.key_col       = POS_W'(col);
		ev.outcome       = oc;
		ev.keys_reported = REP_W'(reported);
		ev.buffer_fill   = slot_count;
		ev.buffer_keys   = '0;
		for (int i = 0; i < BUFFER_SLOTS; i++)
			ev.buffer_keys[i * CODE_W +: CODE_W] = key_slots[i];
		ev.last          = is_last;
		return ev;
	endfunction

	task automatic predict_events(input key_req_t rq);
		int k;
		int n;
		int pos;
		logic [OUTC_W-1:0] oc;
		n = 0;
		case (rq.mode)
			MODE_SCAN: begin
				// all counters move first, then the column-major walk
				for (int c = 0; c < COLS; c++)
					for (int r = 0; r < ROWS; r++) begin
						k = r * COLS + c;
						if (!rq.rows_pressed[c * ROWS + r])
							press_cnt[k] = '0;
						else if (press_cnt[k] != 8'hFF)
							press_cnt[k]++;
					end
				for (int c = 0; c < COLS; c++)
					for (int r = 0; r < ROWS; r++) begin
						k = r * COLS + c;
						if (press_cnt[k] > threshold_model) begin
							press_cnt[k] = '0;
							oc = OUTC_ADDED;
							if (code_map[k] == '0)
								oc = OUTC_PRESENT;
							for (int i = 0; i < slot_count; i++)
								if (key_slots[i] == code_map[k])
									oc = OUTC_PRESENT;
							// present/zero wins over full
							if (oc == OUTC_ADDED && slot_count >= BUFFER_SLOTS)
								oc = OUTC_FULL;
							if (oc == OUTC_ADDED) begin
								key_slots[slot_count] = code_map[k];
								slot_count++;
							end
							expected_events.push_back(
								make_event(KIND_CROSS, code_map[k], r, c, oc, 0, 1'b0));
							n++;
						end
					end
				expected_events.push_back(make_event(KIND_SUMMARY, '0, 0, 0, OUTC_ADDED, n, 1'b1));
			end
			MODE_TABLE: begin
				if (rq.table_index < NKEYS)
					code_map[rq.table_index] = rq.key_code;
				expected_events.push_back(make_event(KIND_TABLE, '0, 0, 0, OUTC_ADDED, 0, 1'b1));
			end
			MODE_REMOVE: begin
				pos = -1;
				for (int i = 0; i < slot_count; i++)
					if (pos < 0 && key_slots[i] == rq.key_code)
						pos = i;
				if (pos < 0) begin
					oc = OUTC_MISSING;
				end else begin
					for (int j = pos; j < BUFFER_SLOTS - 1; j++)
						key_slots[j] = key_slots[j + 1];
					key_slots[BUFFER_SLOTS - 1] = '0;
					slot_count--;
					oc = OUTC_REMOVED;
				end
				expected_events.push_back(make_event(KIND_REMOVE, rq.key_code, 0, 0, oc, 0, 1'b1));
			end
			default: begin
				// mode 3 is dropped without a result
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [KEYS_W-1:0] want,
			input logic [KEYS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			run_failed = 1'b1;
		end
	endtask

	function automatic logic [PRESS_W-1:0] rand_press();
		return {10'($urandom_range(0, 1023)), $urandom};
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			burst_left = 4;
			gap_left = 0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				predict_events(shown_req);
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (queued_requests.size() != 0 &&
						!(queued_requests[0].drain_first && expected_events.size() != 0)) begin
					shown_req = queued_requests.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.mode <= shown_req.mode;
					item_ch.rows_pressed <= shown_req.rows_pressed;
					item_ch.table_index <= shown_req.table_index;
					item_ch.key_code <= shown_req.key_code;
					if (sender_bursty) begin
						burst_left--;
						if (burst_left <= 0) begin
							gap_left = $urandom_range(1, 20);
							burst_left = $urandom_range(1, 12);
						end
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
			pat_pos = 0;
		end else begin
			if (long_hold_pending) begin
				hold_left = LONG_HOLD_CYCLES;
				long_hold_pending = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (sink_style)
					SINK_OPEN: result_ch.ready <= 1'b1;
					SINK_RANDOM: result_ch.ready <= ($urandom_range(0, 2) != 0);
					default: begin
						result_ch.ready <= stall_pattern[pat_pos];
						pat_pos = (pat_pos + 1) % 16;
					end
				endcase
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_events.size() == 0) begin
					$error("result with nothing pending: kind %0d code %0h",
						result_ch.kind, result_ch.event_code);
					run_failed = 1'b1;
				end else begin
					want = expected_events.pop_front();
					check_field("kind", want.kind, result_ch.kind);
					check_field("event_code", want.event_code, result_ch.event_code);
					check_field("key_row", want.key_row, result_ch.key_row);
					check_field("key_col", want.key_col, result_ch.key_col);
					check_field("outcome", want.outcome, result_ch.outcome);
					check_field("keys_reported", want.keys_reported, result_ch.keys_reported);
					check_field("buffer_fill", want.buffer_fill, result_ch.buffer_fill);
					check_field("buffer_keys", want.buffer_keys, result_ch.buffer_keys);
					check_field("last", want.last, result_ch.last);
				end
			end
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$error("no handshake for %0d cycles", STALL_LIMIT);
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	task automatic add_request(input logic [MODE_W-1:0] mode, input logic [PRESS_W-1:0] pressed,
			input logic [TIDX_W-1:0] idx, input logic [CODE_W-1:0] code, input bit drain);
		key_req_t rq;
		rq.mode         = mode;
		rq.rows_pressed = pressed;
		rq.table_index  = idx;
		rq.key_code     = code;
		rq.drain_first  = drain;
		queued_requests.push_back(rq);
	endtask

	task automatic load_code(input int idx, input logic [CODE_W-1:0] code);
		add_request(MODE_TABLE, '0, TIDX_W'(idx), code, 1'b0);
		if (idx < NKEYS && code != '0)
			loaded_codes.push_back(code);
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (queued_requests.size() != 0 || item_ch.valid || expected_events.size() != 0);
		// mode 3 requests leave nothing to wait on
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		threshold_model = value;
	endtask

	task automatic start_phase(input logic [THR_W-1:0] value, input bit bursty, input int style);
		write_threshold(value);
		@(negedge clk);
		sender_bursty = bursty;
		sink_style = style;
		stall_pattern = 16'($urandom) | 16'h0101;
	endtask

	// mostly held keys so counters can climb; some noise scans and other modes
	task automatic random_requests(input int count);
		int pick;
		logic [PRESS_W-1:0] pressed;
		logic [CODE_W-1:0] code;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				if ($urandom_range(0, 9) == 0) begin
					pressed = rand_press();
				end else begin
					if ($urandom_range(0, 3) == 0)
						held_mask[$urandom_range(0, PRESS_W - 1)] ^= 1'b1;
					pressed = held_mask;
				end
				add_request(MODE_SCAN, pressed, TIDX_W'($urandom_range(0, 63)),
					CODE_W'($urandom_range(0, 255)), $urandom_range(0, 79) == 0);
			end else if (pick < 80) begin
				code = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
				if ($urandom_range(0, 7) == 0)
					load_code($urandom_range(NKEYS, 63), code);
				else
					load_code($urandom_range(0, NKEYS - 1), code);
			end else if (pick < 97) begin
				if (loaded_codes.size() != 0 && $urandom_range(0, 3) != 0)
					code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
				else
					code = CODE_W'($urandom_range(0, 255));
				add_request(MODE_REMOVE, rand_press(), TIDX_W'($urandom_range(0, 63)), code,
					1'b0);
			end else begin
				add_request(MODE_IGNORED, rand_press(), TIDX_W'($urandom_range(0, 63)),
					CODE_W'($urandom_range(0, 255)), 1'b0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_SCAN;
		item_ch.rows_pressed = '0;
		item_ch.table_index = '0;
		item_ch.key_code = '0;
		result_ch.ready = 1'b0;
		threshold_model = THRESH_RESET;
		slot_count = '0;
		foreach (press_cnt[i]) begin
			press_cnt[i] = '0;
			code_map[i] = '0;
		end
		foreach (key_slots[i])
			key_slots[i] = '0;
		sender_bursty = 1'b1;
		sink_style = SINK_PATTERN;
		stall_pattern = 16'($urandom) | 16'h0101;
		held_mask = rand_press();
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset threshold: nothing crosses yet
		add_request(MODE_SCAN, '0, '0, '0, 1'b0);
		add_request(MODE_REMOVE, '0, '0, 8'h00, 1'b0);
		add_request(MODE_IGNORED, ALL_KEYS, 6'd63, 8'hFF, 1'b0);
		add_request(MODE_TABLE, '0, 6'd63, 8'hFF, 1'b0);
		add_request(MODE_TABLE, '0, 6'd42, 8'hAA, 1'b0);
		load_code(0, 8'h11);
		load_code(7, 8'h11);
		load_code(14, 8'h40);
		load_code(1, 8'h22);
		load_code(41, 8'hFF);
		load_code(20, 8'h01);
		load_code(30, 8'h80);
		load_code(35, 8'h7F);
		add_request(MODE_SCAN, ALL_KEYS, '0, '0, 1'b0);
		add_request(MODE_SCAN, ALL_KEYS, '1, '1, 1'b0);
		settle();

		// threshold 0: every key crosses, buffer fills, duplicates and zero codes
		start_phase(8'd0, 1'b1, SINK_PATTERN);
		add_request(MODE_SCAN, ALL_KEYS, '0, '0, 1'b0);
		add_request(MODE_SCAN, 42'h2AA_AAAA_AAAA, '0, '0, 1'b0);
		add_request(MODE_REMOVE, '0, '0, 8'h11, 1'b0);
		add_request(MODE_REMOVE, '0, '0, 8'h55, 1'b0);
		add_request(MODE_REMOVE, '0, '0, 8'h00, 1'b0);
		add_request(MODE_REMOVE, '0, '0, 8'h01, 1'b0);
		add_request(MODE_REMOVE, '0, '0, 8'h22, 1'b0);

		// receiver holds off while full scans pile up behind it
		@(negedge clk) long_hold_pending = 1'b1;
		repeat (4) add_request(MODE_SCAN, ALL_KEYS, '0, '0, 1'b0);
		random_requests(20);
		add_request(MODE_TABLE, '0, TIDX_W'($urandom_range(0, NKEYS - 1)),
			CODE_W'($urandom_range(1, 255)), 1'b1);
		random_requests(20);
		settle();

		start_phase(THR_W'($urandom_range(1, 4)), 1'b0, SINK_RANDOM);
		random_requests(40);
		settle();

		// high threshold: a key must be held 31 scans in a row
		start_phase(8'd30, 1'b1, SINK_OPEN);
		repeat (BUFFER_SLOTS)
			add_request(MODE_REMOVE, '0, '0,
				loaded_codes[$urandom_range(0, loaded_codes.size() - 1)], 1'b0);
		held_mask = '0;
		repeat (6) held_mask[$urandom_range(0, PRESS_W - 1)] = 1'b1;
		for (int b = 0; b < PRESS_W; b++)
			if (held_mask[b])
				load_code((b % ROWS) * COLS + b / ROWS, CODE_W'($urandom_range(1, 255)));
		repeat (40)
			add_request(MODE_SCAN, held_mask | (rand_press() & rand_press()), '0, '0, 1'b0);
		settle();

		start_phase(THR_W'($urandom_range(5, 12)), 1'b1, SINK_PATTERN);
		held_mask = rand_press();
		random_requests(40);
		settle();

		if (!run_failed)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
